/* src/button_gesture_and_slider_control_core_defines.svh */
// Assertion macros for the button gesture and slider control core.
// Used by the port checker; needs clk and rst in the scope of each use.
`ifndef BUTTON_GESTURE_AND_SLIDER_CONTROL_CORE_DEFINES_SVH
`define BUTTON_GESTURE_AND_SLIDER_CONTROL_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bgsc_pkg.sv */
// Shared types and constants of the button gesture and slider control core.
// No dependencies; used by the controller, the datapath, the top level and the checker.
`default_nettype none

package bgsc_pkg;

  // Default sizes and fixed widths.
  localparam int TIME_BITS_DEF  = 32;
  localparam int COORD_BITS_DEF = 10;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int QUOT_BITS      = 8;
  localparam int STEP_BITS      = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEBOUNCE,
    REG_MAINT_HOLD,
    REG_PAIR_HOLD,
    REG_DOUBLE_WIN,
    REG_VTEST_DELAY,
    REG_REDRAW_MIN,
    REG_SLIDER_LEFT,
    REG_SLIDER_WIDTH
  } cfg_reg_t;

  // Configuration reset values.
  localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_DATA_BITS-1:0] MAINT_HOLD_RST  = 16'd4000;
  localparam logic [CFG_DATA_BITS-1:0] PAIR_HOLD_RST   = 16'd10000;
  localparam logic [CFG_DATA_BITS-1:0] DOUBLE_WIN_RST  = 16'd400;
  localparam logic [CFG_DATA_BITS-1:0] VTEST_DELAY_RST = 16'd500;
  localparam logic [CFG_DATA_BITS-1:0] REDRAW_MIN_RST  = 16'd50;
  localparam int                       SLIDER_LEFT_RST  = 40;
  localparam int                       SLIDER_WIDTH_RST = 560;

  // Action codes reported with each result.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PAIR_SCAN,
    ACT_STOP_WIFI,
    ACT_MAINT_BOOT,
    ACT_TOGGLE_STEALTH,
    ACT_ENTER_ADJUST,
    ACT_EXIT_SAVE
  } action_t;

  // Slider codes of the touch sample.
  localparam logic [1:0] SLIDER_BRIGHT = 2'd0;
  localparam logic [1:0] SLIDER_VOLUME = 2'd1;

  // Level ranges.
  localparam logic [7:0] BRIGHT_MAX  = 8'd255;
  localparam logic [7:0] BRIGHT_SPAN = 8'd175;
  localparam logic [7:0] BRIGHT_MIN  = 8'd80;
  localparam logic [7:0] VOL_SPAN    = 8'd100;
  localparam logic [6:0] VOL_MAX     = 7'd100;
  localparam logic [6:0] VOL_RST     = 7'd75;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_GESTURE,
    ST_MUL,
    ST_DIV,
    ST_APPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic diff;
    logic gesture;
    logic mul;
    logic div_step;
    logic apply;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slider_hit;
  } status_t;

endpackage

`default_nettype wire

/* src/bgsc_ctrl.sv */
// Controller of the button gesture and slider control core: sequences one beat.
// Depends on bgsc_pkg for the state, command and status types.
`default_nettype none

module bgsc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire bgsc_pkg::status_t  status,
  output bgsc_pkg::cmd_t          cmd
);

  localparam logic [bgsc_pkg::STEP_BITS-1:0] LAST_STEP =
    bgsc_pkg::STEP_BITS'(bgsc_pkg::QUOT_BITS - 1);

  bgsc_pkg::state_t state;
  bgsc_pkg::state_t state_next;
  logic [bgsc_pkg::STEP_BITS-1:0] div_cnt;
  logic [bgsc_pkg::STEP_BITS-1:0] div_cnt_next;

  // State register, divide step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bgsc_pkg::ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    div_cnt_next = '0;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      bgsc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = bgsc_pkg::ST_DIFF;
        end
      end
      bgsc_pkg::ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = bgsc_pkg::ST_GESTURE;
      end
      bgsc_pkg::ST_GESTURE: begin
        cmd.gesture = 1'b1;
        state_next  = status.slider_hit ? bgsc_pkg::ST_MUL : bgsc_pkg::ST_APPLY;
      end
      bgsc_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = bgsc_pkg::ST_DIV;
      end
      bgsc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == LAST_STEP) begin
          div_cnt_next = '0;
          state_next   = bgsc_pkg::ST_APPLY;
        end
      end
      bgsc_pkg::ST_APPLY: begin
        // The result register must be free or emptied in this cycle.
        if (!out_valid || out_ready) begin
          cmd.apply  = 1'b1;
          state_next = bgsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bgsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/bgsc_dpath.sv */
// Datapath of the button gesture and slider control core: configuration,
// gesture state, slider divider and result register. Depends on bgsc_pkg.
`default_nettype none

module bgsc_dpath #(
  parameter int TIME_BITS  = bgsc_pkg::TIME_BITS_DEF,
  parameter int COORD_BITS = bgsc_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire bgsc_pkg::cmd_t                       cmd,
  output bgsc_pkg::status_t                         status,
  input  wire logic                                 cfg_we,
  input  wire logic [bgsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [bgsc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic [TIME_BITS-1:0]                 now_ms,
  input  wire logic                                 button_pressed,
  input  wire logic                                 pair_eligible,
  input  wire logic                                 wifi_setup_active,
  input  wire logic                                 touch_present,
  input  wire logic [COORD_BITS-1:0]                touch_x,
  input  wire logic [1:0]                           touch_slider,
  output logic [2:0]                                action,
  output logic                                      pair_armed,
  output logic                                      pair_armed_changed,
  output logic                                      adjust_active,
  output logic [7:0]                                brightness_level,
  output logic [6:0]                                volume_level,
  output logic                                      stealth_on,
  output logic                                      volume_updated,
  output logic                                      redraw_sliders,
  output logic                                      voice_test_now
);

  localparam int QB        = bgsc_pkg::QUOT_BITS;
  localparam int PROD_BITS = COORD_BITS + QB;

  // Configuration registers.
  logic [bgsc_pkg::CFG_DATA_BITS-1:0] debounce_ms;
  logic [bgsc_pkg::CFG_DATA_BITS-1:0] maint_hold_ms;
  logic [bgsc_pkg::CFG_DATA_BITS-1:0] pair_hold_ms;
  logic [bgsc_pkg::CFG_DATA_BITS-1:0] double_win_ms;
  logic [bgsc_pkg::CFG_DATA_BITS-1:0] vtest_delay_ms;
  logic [bgsc_pkg::CFG_DATA_BITS-1:0] redraw_min_ms;
  logic [COORD_BITS-1:0]              slider_left;
  logic [COORD_BITS-1:0]              slider_width;

  // Latched input beat.
  logic [TIME_BITS-1:0]  in_now;
  logic                  in_pressed;
  logic                  in_eligible;
  logic                  in_wifi;
  logic                  in_touch;
  logic [COORD_BITS-1:0] in_tx;
  logic [1:0]            in_slider;

  // Persistent gesture and slider state.
  logic                 button_was_down;
  logic [TIME_BITS-1:0] press_start_time;
  logic                 pair_armed_flag;
  logic [TIME_BITS-1:0] last_short_release;
  logic                 short_release_valid;
  logic                 adjust_mode;
  logic [7:0]           working_brightness;
  logic [6:0]           working_volume;
  logic [7:0]           saved_brightness;
  logic [6:0]           saved_volume;
  logic                 stealth_setting;
  logic [TIME_BITS-1:0] last_volume_change;
  logic                 volume_test_pending;
  logic [TIME_BITS-1:0] last_redraw_time;

  // Elapsed-time compare flags, registered in the diff step.
  logic ge_pair;
  logic ge_maint;
  logic ge_debounce;
  logic lt_window;
  logic ge_vtest;
  logic ge_redraw;
  logic slider_hit;

  // Gesture outcome carried to the result.
  bgsc_pkg::action_t g_action;
  logic              g_changed;
  logic              g_vol_upd;

  // Serial divider.
  logic [PROD_BITS-1:0] num_rem;
  logic [PROD_BITS-1:0] dsor;
  logic [QB-1:0]        quot;

  // Time differences, modulo the time width.
  logic [TIME_BITS-1:0] pst_eff;
  logic [TIME_BITS-1:0] d_hold;
  logic [TIME_BITS-1:0] d_short;
  logic [TIME_BITS-1:0] d_vol;
  logic [TIME_BITS-1:0] d_redraw;

  assign pst_eff  = (in_pressed && !button_was_down) ? in_now : press_start_time;
  assign d_hold   = in_now - pst_eff;
  assign d_short  = in_now - last_short_release;
  assign d_vol    = in_now - last_volume_change;
  assign d_redraw = in_now - last_redraw_time;

  // Slider geometry; a zero width counts as one pixel.
  logic [COORD_BITS-1:0] width_eff;
  logic [COORD_BITS:0]   right_edge;
  logic                  hit_now;

  assign width_eff  = (slider_width == '0) ? COORD_BITS'(1) : slider_width;
  assign right_edge = (COORD_BITS+1)'(slider_left) + (COORD_BITS+1)'(width_eff);
  assign hit_now    = in_touch
                   && (in_slider == bgsc_pkg::SLIDER_BRIGHT
                       || in_slider == bgsc_pkg::SLIDER_VOLUME)
                   && (in_tx >= slider_left)
                   && ((COORD_BITS+1)'(in_tx) <= right_edge);

  assign status.slider_hit = slider_hit;

  // Scaled offset: offset times the span of the chosen slider.
  logic [COORD_BITS-1:0] offset;
  logic [QB-1:0]         scale;
  logic [PROD_BITS-1:0]  product;

  assign offset  = in_tx - slider_left;
  assign scale   = (in_slider == bgsc_pkg::SLIDER_BRIGHT) ? bgsc_pkg::BRIGHT_SPAN
                                                          : bgsc_pkg::VOL_SPAN;
  assign product = PROD_BITS'(offset) * PROD_BITS'(scale);

  // Gesture classification from the latched beat and the compare flags.
  logic                 arm_req;
  logic [TIME_BITS-1:0] press_start_time_next;
  logic                 pair_armed_flag_next;
  logic [TIME_BITS-1:0] last_short_release_next;
  logic                 short_release_valid_next;
  logic                 adjust_mode_next;
  logic [7:0]           working_brightness_next;
  logic [6:0]           working_volume_next;
  logic [7:0]           saved_brightness_next;
  logic [6:0]           saved_volume_next;
  logic                 stealth_setting_next;
  logic                 volume_test_pending_next;
  bgsc_pkg::action_t    g_action_next;
  logic                 g_changed_next;
  logic                 g_vol_upd_next;

  assign arm_req = !adjust_mode && ge_pair && in_eligible;

  always_comb begin
    press_start_time_next    = pst_eff;
    pair_armed_flag_next     = pair_armed_flag;
    last_short_release_next  = last_short_release;
    short_release_valid_next = short_release_valid;
    adjust_mode_next         = adjust_mode;
    working_brightness_next  = working_brightness;
    working_volume_next      = working_volume;
    saved_brightness_next    = saved_brightness;
    saved_volume_next        = saved_volume;
    stealth_setting_next     = stealth_setting;
    volume_test_pending_next = volume_test_pending;
    g_action_next            = bgsc_pkg::ACT_NONE;
    g_changed_next           = 1'b0;
    g_vol_upd_next           = 1'b0;

    // While held, the armed level follows the hold length and eligibility.
    if (in_pressed && (arm_req != pair_armed_flag)) begin
      pair_armed_flag_next = arm_req;
      g_changed_next       = 1'b1;
    end

    // On release, the hold is classified; the armed flag always drops.
    if (!in_pressed && button_was_down) begin
      if (pair_armed_flag) begin
        pair_armed_flag_next = 1'b0;
        g_changed_next       = 1'b1;
      end
      if (pair_armed_flag && ge_pair) begin
        g_action_next = bgsc_pkg::ACT_PAIR_SCAN;
      end else if (ge_maint) begin
        g_action_next = in_wifi ? bgsc_pkg::ACT_STOP_WIFI : bgsc_pkg::ACT_MAINT_BOOT;
      end else if (ge_debounce) begin
        last_short_release_next  = in_now;
        short_release_valid_next = 1'b1;
        if (short_release_valid && lt_window) begin
          // Double press: if adjusting, leave adjust mode with a save; then toggle stealth.
          short_release_valid_next = 1'b0;
          if (adjust_mode) begin
            adjust_mode_next      = 1'b0;
            saved_brightness_next = working_brightness;
            saved_volume_next     = working_volume;
            g_vol_upd_next        = 1'b1;
          end
          stealth_setting_next = !stealth_setting;
          g_action_next        = bgsc_pkg::ACT_TOGGLE_STEALTH;
        end else if (adjust_mode) begin
          adjust_mode_next      = 1'b0;
          saved_brightness_next = working_brightness;
          saved_volume_next     = working_volume;
          g_vol_upd_next        = 1'b1;
          g_action_next         = bgsc_pkg::ACT_EXIT_SAVE;
        end else begin
          adjust_mode_next         = 1'b1;
          working_brightness_next  = saved_brightness;
          working_volume_next      = saved_volume;
          volume_test_pending_next = 1'b0;
          g_action_next            = bgsc_pkg::ACT_ENTER_ADJUST;
        end
      end
    end
  end

  // Slider levels from the quotient, clamped to their ranges.
  logic [7:0] lvl_bright;
  logic [6:0] lvl_volume;

  assign lvl_bright = (quot >= bgsc_pkg::BRIGHT_SPAN) ? bgsc_pkg::BRIGHT_MIN
                                                      : bgsc_pkg::BRIGHT_MAX - quot;
  assign lvl_volume = (quot >= bgsc_pkg::VOL_SPAN) ? 7'd0
                                                   : bgsc_pkg::VOL_MAX - quot[6:0];

  // Touch handling and the test voice, applied in the last step of the beat.
  logic [7:0]           wb_apply;
  logic [6:0]           wv_apply;
  logic [TIME_BITS-1:0] lrt_apply;
  logic [TIME_BITS-1:0] lvc_apply;
  logic                 pend_apply;
  logic                 redraw_apply;
  logic                 play_apply;
  logic                 vol_upd_apply;

  always_comb begin
    wb_apply      = working_brightness;
    wv_apply      = working_volume;
    lrt_apply     = last_redraw_time;
    lvc_apply     = last_volume_change;
    pend_apply    = volume_test_pending;
    redraw_apply  = 1'b0;
    play_apply    = 1'b0;
    vol_upd_apply = g_vol_upd;
    if (adjust_mode) begin
      if (in_touch) begin
        // A touch off the sliders changes nothing.
        if (slider_hit) begin
          if (in_slider == bgsc_pkg::SLIDER_BRIGHT) begin
            if (lvl_bright != working_brightness) begin
              wb_apply = lvl_bright;
              if (ge_redraw) begin
                redraw_apply = 1'b1;
                lrt_apply    = in_now;
              end
            end
          end else if (lvl_volume != working_volume) begin
            wv_apply      = lvl_volume;
            vol_upd_apply = 1'b1;
            if (ge_redraw) begin
              redraw_apply = 1'b1;
              lrt_apply    = in_now;
            end
            lvc_apply  = in_now;
            pend_apply = 1'b1;
          end
        end
      end else if (volume_test_pending && ge_vtest) begin
        play_apply = 1'b1;
        pend_apply = 1'b0;
      end
    end
  end

  // Control state: configuration and persistent gesture and slider state.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms         <= bgsc_pkg::DEBOUNCE_RST;
      maint_hold_ms       <= bgsc_pkg::MAINT_HOLD_RST;
      pair_hold_ms        <= bgsc_pkg::PAIR_HOLD_RST;
      double_win_ms       <= bgsc_pkg::DOUBLE_WIN_RST;
      vtest_delay_ms      <= bgsc_pkg::VTEST_DELAY_RST;
      redraw_min_ms       <= bgsc_pkg::REDRAW_MIN_RST;
      slider_left         <= COORD_BITS'(bgsc_pkg::SLIDER_LEFT_RST);
      slider_width        <= COORD_BITS'(bgsc_pkg::SLIDER_WIDTH_RST);
      button_was_down     <= 1'b0;
      press_start_time    <= '0;
      pair_armed_flag     <= 1'b0;
      last_short_release  <= '0;
      short_release_valid <= 1'b0;
      adjust_mode         <= 1'b0;
      working_brightness  <= bgsc_pkg::BRIGHT_MAX;
      working_volume      <= bgsc_pkg::VOL_RST;
      saved_brightness    <= bgsc_pkg::BRIGHT_MAX;
      saved_volume        <= bgsc_pkg::VOL_RST;
      stealth_setting     <= 1'b0;
      last_volume_change  <= '0;
      volume_test_pending <= 1'b0;
      last_redraw_time    <= '0;
    end else begin
      if (cfg_we) begin
        case (bgsc_pkg::cfg_reg_t'(cfg_index))
          bgsc_pkg::REG_DEBOUNCE:     debounce_ms    <= cfg_data;
          bgsc_pkg::REG_MAINT_HOLD:   maint_hold_ms  <= cfg_data;
          bgsc_pkg::REG_PAIR_HOLD:    pair_hold_ms   <= cfg_data;
          bgsc_pkg::REG_DOUBLE_WIN:   double_win_ms  <= cfg_data;
          bgsc_pkg::REG_VTEST_DELAY:  vtest_delay_ms <= cfg_data;
          bgsc_pkg::REG_REDRAW_MIN:   redraw_min_ms  <= cfg_data;
          bgsc_pkg::REG_SLIDER_LEFT:  slider_left    <= cfg_data[COORD_BITS-1:0];
          bgsc_pkg::REG_SLIDER_WIDTH: slider_width   <= cfg_data[COORD_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.gesture) begin
        button_was_down     <= in_pressed;
        press_start_time    <= press_start_time_next;
        pair_armed_flag     <= pair_armed_flag_next;
        last_short_release  <= last_short_release_next;
        short_release_valid <= short_release_valid_next;
        adjust_mode         <= adjust_mode_next;
        working_brightness  <= working_brightness_next;
        working_volume      <= working_volume_next;
        saved_brightness    <= saved_brightness_next;
        saved_volume        <= saved_volume_next;
        stealth_setting     <= stealth_setting_next;
        volume_test_pending <= volume_test_pending_next;
      end else if (cmd.apply) begin
        working_brightness  <= wb_apply;
        working_volume      <= wv_apply;
        last_redraw_time    <= lrt_apply;
        last_volume_change  <= lvc_apply;
        volume_test_pending <= pend_apply;
      end
    end
  end

  // Payload registers: input latch, compare flags, divider and result.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_now      <= now_ms;
      in_pressed  <= button_pressed;
      in_eligible <= pair_eligible;
      in_wifi     <= wifi_setup_active;
      in_touch    <= touch_present;
      in_tx       <= touch_x;
      in_slider   <= touch_slider;
    end
    if (cmd.diff) begin
      ge_pair     <= d_hold >= TIME_BITS'(pair_hold_ms);
      ge_maint    <= d_hold >= TIME_BITS'(maint_hold_ms);
      ge_debounce <= d_hold >= TIME_BITS'(debounce_ms);
      lt_window   <= d_short < TIME_BITS'(double_win_ms);
      ge_vtest    <= d_vol >= TIME_BITS'(vtest_delay_ms);
      ge_redraw   <= d_redraw >= TIME_BITS'(redraw_min_ms);
      slider_hit  <= hit_now;
    end
    if (cmd.gesture) begin
      g_action  <= g_action_next;
      g_changed <= g_changed_next;
      g_vol_upd <= g_vol_upd_next;
    end
    // Restoring division, one quotient bit per step, most significant first.
    if (cmd.mul) begin
      num_rem <= product;
      dsor    <= PROD_BITS'(width_eff) << (QB - 1);
      quot    <= '0;
    end else if (cmd.div_step) begin
      if (num_rem >= dsor) begin
        num_rem <= num_rem - dsor;
        quot    <= {quot[QB-2:0], 1'b1};
      end else begin
        quot <= {quot[QB-2:0], 1'b0};
      end
      dsor <= dsor >> 1;
    end
    if (cmd.apply) begin
      action             <= g_action;
      pair_armed         <= pair_armed_flag;
      pair_armed_changed <= g_changed;
      adjust_active      <= adjust_mode;
      brightness_level   <= adjust_mode ? wb_apply : saved_brightness;
      volume_level       <= adjust_mode ? wv_apply : saved_volume;
      stealth_on         <= stealth_setting;
      volume_updated     <= vol_upd_apply;
      redraw_sliders     <= redraw_apply;
      voice_test_now     <= play_apply;
    end
  end

endmodule

`default_nettype wire

/* src/button_gesture_and_slider_control_core.sv */
// Top level of the button gesture and slider control core.
// Instantiates bgsc_ctrl and bgsc_dpath; depends on bgsc_pkg.
`default_nettype none

// One input beat is one millisecond tick and yields exactly one result beat.
// A tick passes through the idle (accepting), diff, gesture and apply states,
// and also through the multiply and divide states when the touch lands on a
// slider (whether or not adjust mode is on): the x offset is scaled and then
// divided by the slider width in a restoring divider that produces one quotient
// bit per cycle. The apply step waits while an earlier result still sits
// unaccepted in the output register. The block takes one tick at a time;
// in_ready is high only between ticks, and a new tick is taken while the
// previous result still waits in the output register. Configuration writes
// take effect at the clock edge of the write.
module button_gesture_and_slider_control_core #(
  parameter int TIME_BITS  = bgsc_pkg::TIME_BITS_DEF,
  parameter int COORD_BITS = bgsc_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [bgsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [bgsc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [TIME_BITS-1:0]                 now_ms,
  input  wire logic                                 button_pressed,
  input  wire logic                                 pair_eligible,
  input  wire logic                                 wifi_setup_active,
  input  wire logic                                 touch_present,
  input  wire logic [COORD_BITS-1:0]                touch_x,
  input  wire logic [1:0]                           touch_slider,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [2:0]                                action,
  output logic                                      pair_armed,
  output logic                                      pair_armed_changed,
  output logic                                      adjust_active,
  output logic [7:0]                                brightness_level,
  output logic [6:0]                                volume_level,
  output logic                                      stealth_on,
  output logic                                      volume_updated,
  output logic                                      redraw_sliders,
  output logic                                      voice_test_now
);

  bgsc_pkg::cmd_t    cmd;
  bgsc_pkg::status_t status;

  // Sequencer and handshakes.
  bgsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // State, arithmetic and result register.
  bgsc_dpath #(
    .TIME_BITS  (TIME_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .now_ms             (now_ms),
    .button_pressed     (button_pressed),
    .pair_eligible      (pair_eligible),
    .wifi_setup_active  (wifi_setup_active),
    .touch_present      (touch_present),
    .touch_x            (touch_x),
    .touch_slider       (touch_slider),
    .action             (action),
    .pair_armed         (pair_armed),
    .pair_armed_changed (pair_armed_changed),
    .adjust_active      (adjust_active),
    .brightness_level   (brightness_level),
    .volume_level       (volume_level),
    .stealth_on         (stealth_on),
    .volume_updated     (volume_updated),
    .redraw_sliders     (redraw_sliders),
    .voice_test_now     (voice_test_now)
  );

endmodule

`default_nettype wire

/* src/bgsc_checker.sv */
// Port-level checker for the button gesture and slider control core, with its bind.
// Depends on bgsc_pkg and the assertion macro header.
`default_nettype none

`include "button_gesture_and_slider_control_core_defines.svh"

module bgsc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] action,
  input wire logic       pair_armed,
  input wire logic       pair_armed_changed,
  input wire logic       adjust_active,
  input wire logic [7:0] brightness_level,
  input wire logic       volume_updated,
  input wire logic       redraw_sliders,
  input wire logic       voice_test_now
);

  // A stalled result beat holds its payload.
  `BGSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(action) && $stable(brightness_level), "result beat changed while stalled")

  // The block works on one tick at a time.
  `BGSC_ASSERT_NEXT(a_one_tick, in_valid && in_ready, !in_ready, "input taken while a tick is in progress")

  // A pairing scan always drops the armed indicator.
  `BGSC_ASSERT_SAME(a_pair_drop, out_valid && action == bgsc_pkg::ACT_PAIR_SCAN, pair_armed_changed && !pair_armed, "pair scan without disarm")

  // Leaving adjust mode applies the saved volume.
  `BGSC_ASSERT_SAME(a_exit_save, out_valid && action == bgsc_pkg::ACT_EXIT_SAVE, !adjust_active && volume_updated, "exit without volume update")

  // Slider effects occur only in adjust mode, and brightness never drops below its floor.
  `BGSC_ASSERT_SAME(a_idle_slider, out_valid && !adjust_active, !redraw_sliders && !voice_test_now && brightness_level >= bgsc_pkg::BRIGHT_MIN, "slider effect outside adjust mode")

endmodule

bind button_gesture_and_slider_control_core bgsc_checker u_bgsc_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .action             (action),
  .pair_armed         (pair_armed),
  .pair_armed_changed (pair_armed_changed),
  .adjust_active      (adjust_active),
  .brightness_level   (brightness_level),
  .volume_updated     (volume_updated),
  .redraw_sliders     (redraw_sliders),
  .voice_test_now     (voice_test_now)
);

`default_nettype wire

/* test/bgsc_gesture_checker.sv */
`timescale 1ns / 1ps
// Checker for the button gesture and slider control core: it watches the input,
// output and register ports, predicts each result beat and compares field by field.
// Depends on bgsc_pkg for register indexes, action codes and level constants.

module bgsc_gesture_checker
  import bgsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [31:0]               now_ms,
  input  logic                      button_pressed,
  input  logic                      pair_eligible,
  input  logic                      wifi_setup_active,
  input  logic                      touch_present,
  input  logic [9:0]                touch_x,
  input  logic [1:0]                touch_slider,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [2:0]                action,
  input  logic                      pair_armed,
  input  logic                      pair_armed_changed,
  input  logic                      adjust_active,
  input  logic [7:0]                brightness_level,
  input  logic [6:0]                volume_level,
  input  logic                      stealth_on,
  input  logic                      volume_updated,
  input  logic                      redraw_sliders,
  input  logic                      voice_test_now,
  output int                        fail_count,
  output int                        pending
);

  // One predicted result beat.
  typedef struct packed {
    action_t    act;
    logic       armed;
    logic       armed_chg;
    logic       adj;
    logic [7:0] bright;
    logic [6:0] vol;
    logic       stealth;
    logic       vol_upd;
    logic       redraw;
    logic       voice;
  } ctrl_result_t;

  ctrl_result_t awaited_results[$];
  int           errors = 0;

  // Register copies and gesture state of the predictor.
  logic [15:0] cfg_regs [8];
  logic        was_down;
  logic [31:0] press_t;
  logic        armed;
  logic [31:0] last_short_t;
  logic        short_valid;
  logic        adjusting;
  logic [7:0]  work_bright;
  logic [7:0]  saved_bright;
  logic [6:0]  work_vol;
  logic [6:0]  saved_vol;
  logic        stealth;
  logic [31:0] last_vol_t;
  logic        vtest_pending;
  logic [31:0] last_redraw_t;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Time differences wrap modulo 2^32.
  function automatic logic [31:0] elapsed(input logic [31:0] later, input logic [31:0] earlier);
    return later - earlier;
  endfunction

  task automatic save_working();
    adjusting    = 1'b0;
    saved_bright = work_bright;
    saved_vol    = work_vol;
  endtask

  // Slider redraws are rate limited by redraw_min_ms.
  task automatic note_redraw(inout ctrl_result_t r);
    if (elapsed(now_ms, last_redraw_t) >= cfg_regs[REG_REDRAW_MIN]) begin
      r.redraw      = 1'b1;
      last_redraw_t = now_ms;
    end
  endtask

  // Advance the model by the tick on the input ports and build its result.
  task automatic predict_tick(output ctrl_result_t r);
    logic [31:0] held;
    logic        arm;
    logic        trig;
    logic        dbl;
    int unsigned left;
    int unsigned width;
    int unsigned off;
    int unsigned dec;
    logic [7:0]  lvl;
    logic [6:0]  vol;
    r = '0;
    r.act = ACT_NONE;
    if (button_pressed && !was_down) press_t = now_ms;
    held = elapsed(now_ms, press_t);

    // Arming follows the hold time, eligibility and adjust mode while held.
    if (button_pressed) begin
      arm = !adjusting && held >= cfg_regs[REG_PAIR_HOLD] && pair_eligible;
      if (arm != armed) begin
        armed       = arm;
        r.armed_chg = 1'b1;
      end
    end

    // Release: pairing, then long hold, then double press, then single press.
    if (!button_pressed && was_down) begin
      trig = armed && held >= cfg_regs[REG_PAIR_HOLD];
      if (armed) begin
        armed       = 1'b0;
        r.armed_chg = 1'b1;
      end
      if (trig) begin
        r.act = ACT_PAIR_SCAN;
      end else if (held >= cfg_regs[REG_MAINT_HOLD]) begin
        r.act = wifi_setup_active ? ACT_STOP_WIFI : ACT_MAINT_BOOT;
      end else if (held >= cfg_regs[REG_DEBOUNCE]) begin
        dbl = short_valid && elapsed(now_ms, last_short_t) < cfg_regs[REG_DOUBLE_WIN];
        last_short_t = now_ms;
        short_valid  = 1'b1;
        if (dbl) begin
          short_valid = 1'b0;
          if (adjusting) begin
            save_working();
            r.vol_upd = 1'b1;
          end
          stealth = !stealth;
          r.act   = ACT_TOGGLE_STEALTH;
        end else if (adjusting) begin
          save_working();
          r.vol_upd = 1'b1;
          r.act     = ACT_EXIT_SAVE;
        end else begin
          adjusting     = 1'b1;
          work_bright   = saved_bright;
          work_vol      = saved_vol;
          vtest_pending = 1'b0;
          r.act         = ACT_ENTER_ADJUST;
        end
      end
    end
    was_down = button_pressed;

    // Slider touches while adjusting; a quiet tick may release the test voice.
    if (adjusting) begin
      if (touch_present) begin
        left  = cfg_regs[REG_SLIDER_LEFT][9:0];
        width = cfg_regs[REG_SLIDER_WIDTH][9:0];
        if (width == 0) width = 1;
        if (touch_slider <= SLIDER_VOLUME && touch_x >= left && touch_x <= left + width) begin
          off = touch_x - left;
          if (touch_slider == SLIDER_BRIGHT) begin
            dec = off * BRIGHT_SPAN / width;
            lvl = (dec >= BRIGHT_SPAN) ? BRIGHT_MIN : 8'(BRIGHT_MAX - dec);
            if (lvl != work_bright) begin
              work_bright = lvl;
              note_redraw(r);
            end
          end else begin
            dec = off * VOL_SPAN / width;
            vol = (dec >= VOL_SPAN) ? 7'd0 : 7'(VOL_MAX - dec);
            if (vol != work_vol) begin
              work_vol  = vol;
              r.vol_upd = 1'b1;
              note_redraw(r);
              last_vol_t    = now_ms;
              vtest_pending = 1'b1;
            end
          end
        end
      end else if (vtest_pending
                   && elapsed(now_ms, last_vol_t) >= cfg_regs[REG_VTEST_DELAY]) begin
        r.voice       = 1'b1;
        vtest_pending = 1'b0;
      end
    end

    r.armed   = armed;
    r.adj     = adjusting;
    r.bright  = adjusting ? work_bright : saved_bright;
    r.vol     = adjusting ? work_vol : saved_vol;
    r.stealth = stealth;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    ctrl_result_t r;
    if (rst) begin
      cfg_regs[REG_DEBOUNCE]     = DEBOUNCE_RST;
      cfg_regs[REG_MAINT_HOLD]   = MAINT_HOLD_RST;
      cfg_regs[REG_PAIR_HOLD]    = PAIR_HOLD_RST;
      cfg_regs[REG_DOUBLE_WIN]   = DOUBLE_WIN_RST;
      cfg_regs[REG_VTEST_DELAY]  = VTEST_DELAY_RST;
      cfg_regs[REG_REDRAW_MIN]   = REDRAW_MIN_RST;
      cfg_regs[REG_SLIDER_LEFT]  = 16'(SLIDER_LEFT_RST);
      cfg_regs[REG_SLIDER_WIDTH] = 16'(SLIDER_WIDTH_RST);
      was_down      = 1'b0;
      press_t       = '0;
      armed         = 1'b0;
      last_short_t  = '0;
      short_valid   = 1'b0;
      adjusting     = 1'b0;
      work_bright   = BRIGHT_MAX;
      saved_bright  = BRIGHT_MAX;
      work_vol      = VOL_RST;
      saved_vol     = VOL_RST;
      stealth       = 1'b0;
      last_vol_t    = '0;
      vtest_pending = 1'b0;
      last_redraw_t = '0;
      awaited_results.delete();
    end else begin
      // A result beat is matched against the oldest prediction.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with no prediction waiting, action %0d", $time, action);
          errors++;
        end else begin
          r = awaited_results.pop_front();
          check_field("action", 8'(r.act), 8'(action));
          check_field("pair_armed", r.armed, pair_armed);
          check_field("pair_armed_changed", r.armed_chg, pair_armed_changed);
          check_field("adjust_active", r.adj, adjust_active);
          check_field("brightness_level", r.bright, brightness_level);
          check_field("volume_level", r.vol, volume_level);
          check_field("stealth_on", r.stealth, stealth_on);
          check_field("volume_updated", r.vol_upd, volume_updated);
          check_field("redraw_sliders", r.redraw, redraw_sliders);
          check_field("voice_test_now", r.voice, voice_test_now);
        end
      end
      if (in_valid && in_ready) begin
        predict_tick(r);
        awaited_results.push_back(r);
      end
      // The slider registers keep only their low ten bits.
      if (cfg_we) begin
        cfg_regs[cfg_index] = (cfg_index >= REG_SLIDER_LEFT) ? (cfg_data & 16'h03FF) : cfg_data;
      end
    end
    fail_count <= errors;
    pending    <= awaited_results.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Top of the button gesture and slider control testbench: clock, reset, tick stimulus,
// register settings and the verdict. Needs bgsc_pkg, the core and bgsc_gesture_checker.

module tb_top;
  import bgsc_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_DEBOUNCE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] now_ms = '0;
  logic        button_pressed = 1'b0;
  logic        pair_eligible = 1'b0;
  logic        wifi_setup_active = 1'b0;
  logic        touch_present = 1'b0;
  logic [9:0]  touch_x = '0;
  logic [1:0]  touch_slider = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  action;
  logic        pair_armed;
  logic        pair_armed_changed;
  logic        adjust_active;
  logic [7:0]  brightness_level;
  logic [6:0]  volume_level;
  logic        stealth_on;
  logic        volume_updated;
  logic        redraw_sliders;
  logic        voice_test_now;
  int          fail_count;
  int          pending;

  // Stimulus bookkeeping.
  int unsigned cur_cfg [8];
  logic [31:0] tnow = '0;
  int          send_idle_pct = 19;
  int          recv_idle_pct = 60;
  int          ticks_sent = 0;
  int          gestures = 0;
  int          settings_used = 1;
  int          cycle_count = 0;

  initial forever #4 clk = ~clk;

  button_gesture_and_slider_control_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .now_ms(now_ms), .button_pressed(button_pressed), .pair_eligible(pair_eligible),
    .wifi_setup_active(wifi_setup_active), .touch_present(touch_present),
    .touch_x(touch_x), .touch_slider(touch_slider),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .pair_armed(pair_armed), .pair_armed_changed(pair_armed_changed),
    .adjust_active(adjust_active), .brightness_level(brightness_level),
    .volume_level(volume_level), .stealth_on(stealth_on), .volume_updated(volume_updated),
    .redraw_sliders(redraw_sliders), .voice_test_now(voice_test_now)
  );

  bgsc_gesture_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .now_ms(now_ms), .button_pressed(button_pressed), .pair_eligible(pair_eligible),
    .wifi_setup_active(wifi_setup_active), .touch_present(touch_present),
    .touch_x(touch_x), .touch_slider(touch_slider),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .pair_armed(pair_armed), .pair_armed_changed(pair_armed_changed),
    .adjust_active(adjust_active), .brightness_level(brightness_level),
    .volume_level(volume_level), .stealth_on(stealth_on), .volume_updated(volume_updated),
    .redraw_sliders(redraw_sliders), .voice_test_now(voice_test_now),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stalls at random, independent of out_valid.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one tick beat and hold it until accepted; valid drops only for a gap.
  task automatic send_tick(input logic [31:0] t, input logic pr, input logic el,
                           input logic wf, input logic tp, input logic [9:0] x,
                           input logic [1:0] sl);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid          <= 1'b1;
    now_ms            <= t;
    button_pressed    <= pr;
    pair_eligible     <= el;
    wifi_setup_active <= wf;
    touch_present     <= tp;
    touch_x           <= x;
    touch_slider      <= sl;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // Pause the sender until every predicted result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers on an idle block.
  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] maint,
                                input logic [15:0] pair, input logic [15:0] win,
                                input logic [15:0] vdel, input logic [15:0] redraw,
                                input logic [15:0] left, input logic [15:0] width);
    logic [15:0] vals [8];
    vals = '{deb, maint, pair, win, vdel, redraw, left, width};
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we     <= 1'b1;
      cfg_index  <= cfg_reg_t'(i);
      cfg_data   <= vals[i];
      cur_cfg[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Hold lengths cluster around the thresholds, with the short band favored.
  function automatic logic [31:0] pick_hold();
    int unsigned deb;
    int unsigned maint;
    int unsigned pair;
    int unsigned top;
    deb   = cur_cfg[REG_DEBOUNCE];
    maint = cur_cfg[REG_MAINT_HOLD];
    pair  = cur_cfg[REG_PAIR_HOLD];
    top   = (maint < pair) ? maint : pair;
    top   = (top > deb) ? top - 1 : deb;
    case ($urandom_range(0, 13))
      0:         return deb - 1;
      1:         return deb;
      2, 3, 4, 5, 6: return $urandom_range(deb, top);
      7:         return maint - 1;
      8:         return maint;
      9:         return maint + $urandom_range(0, 20);
      10:        return pair - 1;
      11:        return pair;
      12:        return pair + $urandom_range(0, 20);
      default:   return $urandom();
    endcase
  endfunction

  // A tick at the running time with a random touch sample, mostly near the slider.
  task automatic send_live(input logic pr, input logic el);
    int unsigned lo;
    int unsigned hi;
    logic [9:0]  x;
    logic [1:0]  sl;
    lo = cur_cfg[REG_SLIDER_LEFT];
    hi = lo + cur_cfg[REG_SLIDER_WIDTH];
    if ($urandom_range(0, 9) < 7) begin
      x = 10'($urandom_range((lo > 3) ? lo - 3 : 0, (hi + 3 > 1023) ? 1023 : hi + 3));
    end else begin
      x = 10'($urandom());
    end
    sl = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
    send_tick(tnow, pr, el, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, x, sl);
  endtask

  // Press, a few held ticks, then the release.
  task automatic press_gesture();
    logic [31:0] hold;
    logic [31:0] t0;
    logic        elig;
    int          mids;
    hold = pick_hold();
    elig = ($urandom_range(0, 9) != 0);
    t0   = tnow;
    mids = $urandom_range(0, 3);
    gestures++;
    send_live(1'b1, elig);
    repeat (mids) begin
      tnow = tnow + $urandom_range(0, hold - (tnow - t0));
      send_live(1'b1, ($urandom_range(0, 6) == 0) ? !elig : elig);
    end
    tnow = t0 + hold;
    if ($urandom_range(0, 1) != 0) send_live(1'b1, elig);
    send_live(1'b0, elig);
  endtask

  // Released ticks between presses, spaced for double presses, redraws and the test voice.
  task automatic gap_ticks();
    int n;
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       tnow += $urandom_range(0, 3);
        1:       tnow += $urandom_range(0, cur_cfg[REG_DOUBLE_WIN]);
        2:       tnow += $urandom_range(0, cur_cfg[REG_VTEST_DELAY] + cur_cfg[REG_REDRAW_MIN]);
        default: tnow += $urandom_range(0, 3 * cur_cfg[REG_VTEST_DELAY] + 10);
      endcase
      send_live(1'b0, 1'($urandom_range(0, 1)));
    end
    tnow += $urandom_range(0, cur_cfg[REG_DOUBLE_WIN] / 2 + 1);
  endtask

  // Mostly whole gestures, some raw noise beats and the odd full pause.
  task automatic run_random(input int n);
    int stop_at;
    stop_at = ticks_sent + n;
    tnow    = $urandom();
    while (ticks_sent < stop_at) begin
      case ($urandom_range(0, 29))
        0: send_tick($urandom(), 1'($urandom()), 1'($urandom()), 1'($urandom()),
                     1'($urandom()), 10'($urandom()), 2'($urandom()));
        1: drain();
        default: begin
          press_gesture();
          gap_ticks();
        end
      endcase
    end
  endtask

  initial begin
    cur_cfg = '{DEBOUNCE_RST, MAINT_HOLD_RST, PAIR_HOLD_RST, DOUBLE_WIN_RST,
                VTEST_DELAY_RST, REDRAW_MIN_RST, SLIDER_LEFT_RST, SLIDER_WIDTH_RST};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks on the reset settings.
    // Short press enters adjust mode; touches cover both slider ends and off-slider.
    send_tick(32'd10,   1'b1, 1'b1, 1'b0, 1'b0, 10'd0,    2'd2);
    send_tick(32'd100,  1'b0, 1'b1, 1'b0, 1'b1, 10'd40,   2'd0);
    send_tick(32'd120,  1'b0, 1'b1, 1'b0, 1'b1, 10'd600,  2'd0);
    send_tick(32'd130,  1'b0, 1'b1, 1'b0, 1'b1, 10'd1023, 2'd0);
    send_tick(32'd140,  1'b0, 1'b1, 1'b0, 1'b1, 10'd40,   2'd1);
    send_tick(32'd200,  1'b0, 1'b1, 1'b0, 1'b1, 10'd600,  2'd1);
    send_tick(32'd260,  1'b0, 1'b1, 1'b0, 1'b1, 10'd300,  2'd3);
    // Quiet tick after the delay plays the test voice.
    send_tick(32'd800,  1'b0, 1'b1, 1'b0, 1'b0, 10'd300,  2'd1);
    // Single press leaves and saves, then a double press toggles stealth.
    send_tick(32'd1000, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd1100, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd1200, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd1300, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0,    2'd0);
    // Enter adjust, then a double press while adjusting.
    send_tick(32'd2000, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd2100, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd2200, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd2300, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0,    2'd0);
    // Bounce, wifi stop and maintenance holds.
    send_tick(32'd3000, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd3010, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd4000, 1'b1, 1'b0, 1'b1, 1'b0, 10'd0,    2'd0);
    send_tick(32'd8000, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0,    2'd0);
    send_tick(32'd9000, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0,    2'd0);
    send_tick(32'd13000, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0,   2'd0);
    // Armed pairing hold, then a short press across the time wrap.
    send_tick(32'd20000, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0,   2'd0);
    send_tick(32'd30000, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0,   2'd0);
    send_tick(32'd30001, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0,   2'd0);
    send_tick(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0, 2'd0);
    send_tick(32'h0000_0040, 1'b0, 1'b1, 1'b0, 1'b1, 10'd320, 2'd0);

    // Sender lightly stalled, receiver heavily stalled.
    apply_settings(16'd5, 16'd40, 16'd80, 16'd30, 16'd20, 16'd10, 16'd40, 16'd560);
    run_random(100);
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(40);

    // Roles swapped.
    send_idle_pct = 60;
    recv_idle_pct = 19;
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'd1023, 16'd1023);
    run_random(40);
    apply_settings(16'd3, 16'd25, 16'd60, 16'd20, 16'd15, 16'd5, 16'd100, 16'd200);
    run_random(100);

    // No stalls on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(16'd2, 16'd30, 16'd50, 16'd25, 16'd10, 16'd0, 16'd500, 16'd523);
    run_random(80);
    apply_settings(DEBOUNCE_RST, MAINT_HOLD_RST, PAIR_HOLD_RST, DOUBLE_WIN_RST,
                   VTEST_DELAY_RST, REDRAW_MIN_RST, 16'(SLIDER_LEFT_RST),
                   16'(SLIDER_WIDTH_RST));
    run_random(60);

    drain();
    $display("Ran %0d ticks and %0d press gestures over %0d register settings,",
             ticks_sent, gestures, settings_used);
    $display("with stalls on either side, then none, and %0d mismatches.", fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
